FILE: rtl/dsa_pkg.sv
// Shared types and codes for the descriptor slot allocator.
// No dependencies; imported by dsa_ctrl and descriptor_slot_allocator_unit.
package dsa_pkg;

    localparam int HANDLE_W = 32;

    typedef logic [1:0] op_t;
    localparam op_t OP_INSTALL   = 2'd0;
    localparam op_t OP_LOOKUP    = 2'd1;
    localparam op_t OP_UNINSTALL = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_FULL     = 2'd1;
    localparam status_t STATUS_BAD_SLOT = 2'd2;

    typedef logic [HANDLE_W-1:0] handle_t;

    // Strobes from the controller to the entry memory.
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

FILE: rtl/dsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/dsa_ctrl.sv
// Sequencer of the slot allocator: bump pointer, free-list head, entry
// read-modify-write and the result register. Depends on dsa_pkg.
module dsa_ctrl #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FIRST_SLOT  = 3,
    localparam int SLOT_W     = $clog2(TABLE_DEPTH),
    localparam int ENTRY_W    = 1 + SLOT_W + dsa_pkg::HANDLE_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dsa_pkg::op_t       operation,
    input  logic [SLOT_W-1:0]  slot_number,
    input  dsa_pkg::handle_t   handle_in,
    output logic               out_valid,
    input  logic               out_stall,
    output dsa_pkg::status_t   status,
    output logic [SLOT_W-1:0]  slot_out,
    output dsa_pkg::handle_t   handle_out,
    output dsa_pkg::mem_cmd_t  mem_cmd,
    output logic [SLOT_W-1:0]  rd_addr,
    output logic [SLOT_W-1:0]  wr_addr,
    output logic [ENTRY_W-1:0] wr_data,
    input  logic [ENTRY_W-1:0] rd_data
);

    import dsa_pkg::*;

    localparam logic [SLOT_W:0]   DEPTH_C = (SLOT_W+1)'(TABLE_DEPTH);
    localparam logic [SLOT_W-1:0] FIRST_C = SLOT_W'(FIRST_SLOT);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    handle_t           handle_reg, handle_next;
    logic [SLOT_W:0]   bump_reg, bump_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic [SLOT_W-1:0] slot_out_reg, slot_out_next;
    handle_t           handle_out_reg, handle_out_next;

    logic              accept;
    logic              done;
    logic              rd_valid;
    logic [SLOT_W-1:0] rd_link;
    handle_t           rd_handle;
    logic              bump_avail;
    logic              free_avail;
    logic              slot_ok;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_out   = slot_out_reg;
    assign handle_out = handle_out_reg;

    // Installs read the head entry for its link; others read the named slot.
    assign rd_addr = (operation == OP_INSTALL) ? head_reg : slot_number;

    assign rd_valid  = rd_data[ENTRY_W-1];
    assign rd_link   = rd_data[HANDLE_W +: SLOT_W];
    assign rd_handle = rd_data[HANDLE_W-1:0];

    // Result register free or drained this cycle.
    assign done = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    assign bump_avail = (bump_reg < DEPTH_C);
    assign free_avail = (head_reg != '0) && ({1'b0, head_reg} < DEPTH_C);
    // Entries at or above the bump pointer were never written: treat as free.
    assign slot_ok = (slot_reg >= FIRST_C) && ({1'b0, slot_reg} < DEPTH_C)
                     && ({1'b0, slot_reg} < bump_reg) && rd_valid;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        handle_next     = handle_reg;
        bump_next       = bump_reg;
        head_next       = head_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        slot_out_next   = slot_out_reg;
        handle_out_next = handle_out_reg;
        mem_cmd.rd      = accept;
        mem_cmd.wr      = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = {1'b1, rd_link, handle_reg};

        if (accept)
        begin
            op_next     = operation;
            slot_next   = slot_number;
            handle_next = handle_in;
            state_next  = S_EXEC;
        end

        if (done)
        begin
            state_next      = S_IDLE;
            out_valid_next  = 1'b1;
            status_next     = STATUS_BAD_SLOT;
            slot_out_next   = '0;
            handle_out_next = '0;
            unique case (op_reg)
                OP_INSTALL:
                begin
                    priority if (bump_avail)
                    begin
                        mem_cmd.wr    = 1'b1;
                        wr_addr       = bump_reg[SLOT_W-1:0];
                        bump_next     = bump_reg + (SLOT_W+1)'(1);
                        status_next   = STATUS_OK;
                        slot_out_next = bump_reg[SLOT_W-1:0];
                    end
                    else if (free_avail)
                    begin
                        // Pop: the link read at accept becomes the new head.
                        mem_cmd.wr    = 1'b1;
                        wr_addr       = head_reg;
                        head_next     = rd_link;
                        status_next   = STATUS_OK;
                        slot_out_next = head_reg;
                    end
                    else
                    begin
                        status_next = STATUS_FULL;
                    end
                end
                OP_LOOKUP:
                begin
                    if (slot_ok)
                    begin
                        status_next     = STATUS_OK;
                        slot_out_next   = slot_reg;
                        handle_out_next = rd_handle;
                    end
                end
                OP_UNINSTALL:
                begin
                    if (slot_ok)
                    begin
                        // Push: clear valid, link to the old head, keep handle.
                        mem_cmd.wr      = 1'b1;
                        wr_data         = {1'b0, head_reg, rd_handle};
                        head_next       = slot_reg;
                        status_next     = STATUS_OK;
                        slot_out_next   = slot_reg;
                        handle_out_next = rd_handle;
                    end
                end
                default:
                begin
                    status_next = STATUS_BAD_SLOT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_INSTALL;
            slot_reg       <= '0;
            handle_reg     <= '0;
            bump_reg       <= (SLOT_W+1)'(FIRST_SLOT);
            head_reg       <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= STATUS_OK;
            slot_out_reg   <= '0;
            handle_out_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            slot_reg       <= slot_next;
            handle_reg     <= handle_next;
            bump_reg       <= bump_next;
            head_reg       <= head_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            slot_out_reg   <= slot_out_next;
            handle_out_reg <= handle_out_next;
        end
    end

endmodule

FILE: rtl/descriptor_slot_allocator_unit.sv
// Top level of the descriptor slot allocator: controller plus entry memory.
// Depends on dsa_pkg, dsa_ctrl and dsa_ram.

// Each item first reads the slot's entry from the synchronous entry
// memory (valid bit, free-list link, handle), then updates it and loads
// the result register, so a new item is accepted only after the last one
// has finished its update; the registered read data of that memory sets
// this. A new item is accepted while a finished result still waits in
// the result register; a result that is still stalled when the next item
// reaches its update holds that item there. Slots start out free and need
// no clearing pass after reset: the bump pointer doubles as a fill count,
// so entries at or above it read as not in use.
module descriptor_slot_allocator_unit #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FIRST_SLOT  = 3,
    localparam int SLOT_W     = $clog2(TABLE_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  dsa_pkg::op_t      operation,
    input  logic [SLOT_W-1:0] slot_number,
    input  dsa_pkg::handle_t  handle_in,
    output logic              out_valid,
    input  logic              out_stall,
    output dsa_pkg::status_t  status,
    output logic [SLOT_W-1:0] slot_out,
    output dsa_pkg::handle_t  handle_out
);

    import dsa_pkg::*;

    localparam int ENTRY_W = 1 + SLOT_W + HANDLE_W;

    mem_cmd_t           mem_cmd;
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;

    dsa_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FIRST_SLOT  (FIRST_SLOT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .slot_number (slot_number),
        .handle_in   (handle_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot_out    (slot_out),
        .handle_out  (handle_out),
        .mem_cmd     (mem_cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_data     (rd_data)
    );

    dsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (mem_cmd.wr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (mem_cmd.rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

`ifndef SYNTH
    // Read and write-back of an item never share a cycle.
    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_cmd.rd && mem_cmd.wr))
        else $error("entry memory read and write in the same cycle");

    // A write-back always comes with a new result.
    a_wr_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        mem_cmd.wr |=> out_valid)
        else $error("entry write without a result");

    // An accepted item holds the input side while its entry is read.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted during entry read");

    // Reserved slots are never handed out or echoed.
    a_ok_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_OK) |-> (slot_out >= SLOT_W'(FIRST_SLOT)))
        else $error("reserved slot in a successful result");

    // Failures carry zero slot and handle.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> (slot_out == '0 && handle_out == '0))
        else $error("failure result with nonzero payload");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for descriptor_slot_allocator_unit: random handshake
// traffic checked against a slot-table predictor kept in step with accepted items.
// Depends on dsa_pkg and the RTL of descriptor_slot_allocator_unit.
`timescale 1ns / 1ps

module tb_top;

    import dsa_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int FIRST_SLOT = 3;
    localparam op_t OP_UNDEFINED = 2'd3;

    typedef struct {
        op_t          op;
        logic [9:0]   slot;
        handle_t      handle;
    } request_t;

    typedef struct {
        status_t      status;
        logic [9:0]   slot;
        handle_t      handle;
    } reply_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    op_t        operation = OP_INSTALL;
    logic [9:0] slot_number = '0;
    handle_t    handle_in = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    status_t    status;
    logic [9:0] slot_out;
    handle_t    handle_out;

    // Slot table as the block should hold it after every accepted item.
    bit         slot_live [DEPTH];
    bit [31:0]  slot_owner [DEPTH];
    bit [9:0]   slot_next_free [DEPTH];
    bit [10:0]  bump_slot = 11'(FIRST_SLOT);
    bit [9:0]   free_list_top = '0;

    request_t   pending [$];
    reply_t     awaited_replies [$];
    int         mismatches = 0;

    descriptor_slot_allocator_unit #(
        .TABLE_DEPTH(DEPTH),
        .FIRST_SLOT (FIRST_SLOT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .slot_number(slot_number),
        .handle_in  (handle_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot_out   (slot_out),
        .handle_out (handle_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic reply_t apply_request(request_t r);
        reply_t     rep;
        logic [9:0] got;
        bit         granted;
        rep.status = STATUS_BAD_SLOT;
        rep.slot   = '0;
        rep.handle = '0;
        granted    = 1'b0;
        got        = '0;
        case (r.op)
            OP_INSTALL:
            begin
                if (bump_slot < DEPTH)
                begin
                    got       = bump_slot[9:0];
                    bump_slot = bump_slot + 11'd1;
                    granted   = 1'b1;
                end
                else if (free_list_top != 0)
                begin
                    got           = free_list_top;
                    free_list_top = slot_next_free[got];
                    granted       = 1'b1;
                end
                if (granted)
                begin
                    slot_owner[got] = r.handle;
                    slot_live[got]  = 1'b1;
                    rep.status      = STATUS_OK;
                    rep.slot        = got;
                end
                else
                    rep.status = STATUS_FULL;
            end
            OP_LOOKUP, OP_UNINSTALL:
            begin
                if (r.slot >= FIRST_SLOT && slot_live[r.slot])
                begin
                    rep.status = STATUS_OK;
                    rep.slot   = r.slot;
                    rep.handle = slot_owner[r.slot];
                    if (r.op == OP_UNINSTALL)
                    begin
                        slot_live[r.slot]      = 1'b0;
                        slot_next_free[r.slot] = free_list_top;
                        free_list_top          = r.slot;
                    end
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    // Mostly returns an in-use slot; falls back to whatever the last try gave.
    function automatic logic [9:0] pick_live_slot();
        logic [9:0] s;
        int         top;
        top = (bump_slot >= DEPTH) ? DEPTH - 1 : int'(bump_slot) - 1;
        if (top < FIRST_SLOT)
            top = FIRST_SLOT;
        s = 10'(FIRST_SLOT);
        for (int i = 0; i < 16; i++)
        begin
            s = 10'($urandom_range(FIRST_SLOT, top));
            if (slot_live[s])
                return s;
        end
        return s;
    endfunction

    function automatic request_t random_request(int install_pct);
        request_t r;
        int       roll;
        r.op     = OP_INSTALL;
        r.slot   = 10'($urandom_range(0, DEPTH - 1));
        r.handle = $urandom();
        roll     = $urandom_range(0, 99);
        if (roll < install_pct)
            r.op = OP_INSTALL;
        else if (roll < 90)
        begin
            r.op   = (roll % 4 == 0) ? OP_LOOKUP : OP_UNINSTALL;
            r.slot = pick_live_slot();
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: r.op = OP_UNDEFINED;
                1:
                begin
                    // hit the slot most recently freed
                    r.op   = ($urandom_range(0, 1) == 0) ? OP_LOOKUP : OP_UNINSTALL;
                    r.slot = free_list_top;
                end
                default: r.op = ($urandom_range(0, 1) == 0) ? OP_LOOKUP : OP_UNINSTALL;
            endcase
        end
        return r;
    endfunction

    task automatic queue_request(op_t op, logic [9:0] slot, handle_t handle);
        request_t r;
        r.op     = op;
        r.slot   = slot;
        r.handle = handle;
        pending.push_back(r);
    endtask

    task automatic queue_random(int count, int install_pct, bit until_exhausted);
        int n;
        n = 0;
        while (until_exhausted ? (bump_slot < DEPTH) : (n < count))
        begin
            while (pending.size() >= 4)
                @(negedge clk);
            pending.push_back(random_request(install_pct));
            n++;
            if (until_exhausted && n == 300)
            begin
                // pause the sender until the block has drained
                while (pending.size() != 0 || in_valid || awaited_replies.size() != 0)
                    @(negedge clk);
            end
        end
    endtask

    // Sender: bursts of random length with random gaps; hold a stalled item.
    int       burst_left = 0;
    int       gap_left = 0;
    request_t next_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            operation   <= OP_INSTALL;
            slot_number <= '0;
            handle_in   <= '0;
            burst_left  = 0;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                next_req.op     = operation;
                next_req.slot   = slot_number;
                next_req.handle = handle_in;
                awaited_replies.push_back(apply_request(next_req));
            end
            if (in_valid && in_stall)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending.size() > 0)
            begin
                next_req = pending.pop_front();
                operation   <= next_req.op;
                slot_number <= next_req.slot;
                handle_in   <= next_req.handle;
                in_valid    <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall modes of random length, plus one long hold-off.
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int taken = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode = 0;
            mode_left  = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
            taken      = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                taken++;
            if (!hold_done && taken >= 400)
            begin
                hold_done = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(8, 60);
                end
                mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual status %0h slot %0h handle %0h",
                         $time, status, slot_out, handle_out);
                mismatches++;
            end
            else
            begin
                reply_t want;
                want = awaited_replies.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("slot_out", 32'(want.slot), 32'(slot_out));
                check_field("handle_out", want.handle, handle_out);
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reserved, unused and undefined requests, then a small install/free cycle
        queue_request(OP_LOOKUP, 10'd0, 32'h1234_5678);
        queue_request(OP_UNINSTALL, 10'd2, '0);
        queue_request(OP_LOOKUP, 10'd1023, '0);
        queue_request(OP_UNDEFINED, 10'd5, 32'hFFFF_FFFF);
        queue_request(OP_INSTALL, 10'd1023, 32'h0000_0000);
        queue_request(OP_INSTALL, 10'd0, 32'hFFFF_FFFF);
        queue_request(OP_INSTALL, 10'd512, 32'hA5A5_5A5A);
        queue_request(OP_LOOKUP, 10'd3, '0);
        queue_request(OP_LOOKUP, 10'd4, 32'hFFFF_FFFF);
        queue_request(OP_UNINSTALL, 10'd4, '0);
        queue_request(OP_LOOKUP, 10'd4, '0);
        queue_request(OP_UNINSTALL, 10'd4, '0);
        queue_request(OP_UNINSTALL, 10'd3, '0);
        queue_request(OP_INSTALL, 10'd3, 32'h8000_0001);
        queue_request(OP_LOOKUP, 10'd6, '0);
        queue_request(OP_LOOKUP, 10'd5, '0);
        queue_request(OP_UNINSTALL, 10'd1023, 32'hFFFF_FFFF);
        queue_request(OP_LOOKUP, 10'd1, '0);
        queue_request(OP_UNDEFINED, 10'd0, '0);
        queue_request(OP_UNDEFINED, 10'd1023, 32'h5555_AAAA);

        // fill the table past the bump pointer, then churn the free list
        queue_random(0, 88, 1'b1);
        queue_random(200, 30, 1'b0);
        queue_random(250, 55, 1'b0);

        while (pending.size() != 0 || in_valid)
            @(negedge clk);
        while (awaited_replies.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
